// File: rtl/tmap_pkg.sv
// ----------------------------------------------------------------------------
// Tempo map package
// Shared types and constants for the tick-to-time tempo map.
// ----------------------------------------------------------------------------
package tmap_pkg;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned TEMPO_W = 24;
  localparam int unsigned TIME_W  = 56;
  localparam int unsigned TPQ_W   = 15;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned STAT_W  = 2;

  // Bits retired by the restoring divider, and the counter that walks them
  localparam int unsigned DIV_CNT_W = $clog2(TIME_W);

  localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = 24'd500000;
  localparam logic [TPQ_W-1:0]   TPQ_RESET     = 15'd1;

  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CONVERT = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ORDER = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [TEMPO_W-1:0] tempo;
    logic [TICK_W-1:0]  tick;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_CMP  = 6'b000100,
    S_MUL  = 6'b001000,
    S_ACC  = 6'b010000,
    S_DIV  = 6'b100000
  } state_t;

endpackage

// File: rtl/tmap_ram.sv
// ----------------------------------------------------------------------------
// Tempo map RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tempo_map_tick_to_time.sv
// ----------------------------------------------------------------------------
// Tempo map tick-to-time converter
// Keeps an ascending tempo map and converts absolute ticks to microseconds.
// ----------------------------------------------------------------------------
// Clear and append: the result is valid in the cycle after the request is taken.
// Convert: read, compare, multiply and accumulate per map entry below the tick, the
// same for the last segment or no compare at the map end, then the one-bit-per-cycle
// restoring divider; one 32x24 multiplier is shared. One request is in flight at a
// time; the next is taken once the result has left. Reset (rst_n low, synchronous)
// restores entry 0 (500000 us per quarter at tick 0) and a division of 1; map RAM is kept.
module tempo_map_tick_to_time #(
  parameter int unsigned MAX_TEMPO_CHANGES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,     // ticks_per_quarter
  // request
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,      // [31:0] tick, [55:32] us_per_quarter
  input  logic [1:0]  in_tuser,      // [1:0] action
  // result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata      // [55:0] time_us, [57:56] status
);

  localparam int unsigned AW = (MAX_TEMPO_CHANGES > 1) ? $clog2(MAX_TEMPO_CHANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_TEMPO_CHANGES + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_TEMPO_CHANGES);
  localparam logic [CW-1:0] COUNT_ONE = CW'(1);

  localparam int unsigned TICK_W  = tmap_pkg::TICK_W;
  localparam int unsigned TEMPO_W = tmap_pkg::TEMPO_W;
  localparam int unsigned TIME_W  = tmap_pkg::TIME_W;
  localparam int unsigned TPQ_W   = tmap_pkg::TPQ_W;
  localparam int unsigned DCW     = tmap_pkg::DIV_CNT_W;

  tmap_pkg::state_t state_r, state_nxt;

  logic [TPQ_W-1:0]    tpq_r;
  logic [TEMPO_W-1:0]  tempo0_r, tempo0_nxt;
  logic                dflt_r, dflt_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [TICK_W-1:0]   last_tick_r, last_tick_nxt;

  logic [TICK_W-1:0]   t_r, t_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [TICK_W-1:0]   cur_tick_r, cur_tick_nxt;
  logic [TEMPO_W-1:0]  cur_tempo_r, cur_tempo_nxt;
  logic                final_r, final_nxt;
  logic [TICK_W-1:0]   mul_a_r, mul_a_nxt;
  logic [TEMPO_W-1:0]  mul_b_r, mul_b_nxt;
  logic [TIME_W-1:0]   prod_r, prod_nxt;
  logic [TIME_W-1:0]   sum_r, sum_nxt;
  logic [TPQ_W-1:0]    rem_r, rem_nxt;
  logic [DCW-1:0]      bit_cnt_r, bit_cnt_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]          out_time_r, out_time_nxt;
  logic [tmap_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic                  ram_we;
  tmap_pkg::entry_t      ram_wdata;
  tmap_pkg::entry_t      ram_rdata;
  logic [tmap_pkg::ENTRY_W-1:0] ram_rbits;

  logic [TICK_W-1:0]     req_tick;
  logic [TEMPO_W-1:0]    req_tempo;
  logic [tmap_pkg::ACT_W-1:0] req_act;
  logic                  req_take;
  logic [TPQ_W-1:0]      divisor;
  logic [TPQ_W:0]        rem_sh;
  logic                  q_bit;

  assign req_tick  = in_tdata[TICK_W-1:0];
  assign req_tempo = in_tdata[TICK_W+TEMPO_W-1:TICK_W];
  assign req_act   = in_tuser;

  assign in_tready = (state_r == tmap_pkg::S_IDLE) && !out_valid_r;
  assign req_take  = in_tvalid && in_tready;

  assign ram_rdata = tmap_pkg::entry_t'(ram_rbits);
  assign ram_wdata = '{tempo: req_tempo, tick: req_tick};

  // Zero division is taken as one
  assign divisor = (tpq_r == '0) ? TPQ_W'(1) : tpq_r;
  assign rem_sh  = {rem_r, sum_r[TIME_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, divisor});

  tmap_ram #(
    .WIDTH (tmap_pkg::ENTRY_W),
    .DEPTH (MAX_TEMPO_CHANGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (k_r[AW-1:0]),
    .rdata (ram_rbits)
  );

  always_comb begin
    state_nxt     = state_r;
    tempo0_nxt    = tempo0_r;
    dflt_nxt      = dflt_r;
    count_nxt     = count_r;
    last_tick_nxt = last_tick_r;
    t_nxt         = t_r;
    k_nxt         = k_r;
    cur_tick_nxt  = cur_tick_r;
    cur_tempo_nxt = cur_tempo_r;
    final_nxt     = final_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_time_nxt  = out_time_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;

    case (state_r)
      tmap_pkg::S_IDLE: begin
        if (req_take) begin
          out_time_nxt = '0;
          out_stat_nxt = tmap_pkg::STAT_OK;
          case (req_act)
            tmap_pkg::ACT_CLEAR: begin
              tempo0_nxt    = tmap_pkg::DEFAULT_TEMPO;
              dflt_nxt      = 1'b1;
              count_nxt     = COUNT_ONE;
              last_tick_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            tmap_pkg::ACT_APPEND: begin
              out_valid_nxt = 1'b1;
              if (req_tick == '0) begin
                // Tick zero may only replace the default entry
                if (dflt_r) begin
                  tempo0_nxt = req_tempo;
                  dflt_nxt   = 1'b0;
                end else begin
                  out_stat_nxt = tmap_pkg::STAT_ORDER;
                end
              end else if (req_tick <= last_tick_r) begin
                out_stat_nxt = tmap_pkg::STAT_ORDER;
              end else if (count_r == COUNT_MAX) begin
                out_stat_nxt = tmap_pkg::STAT_FULL;
              end else begin
                ram_we        = 1'b1;
                count_nxt     = count_r + COUNT_ONE;
                last_tick_nxt = req_tick;
              end
            end
            tmap_pkg::ACT_CONVERT: begin
              t_nxt         = req_tick;
              k_nxt         = COUNT_ONE;
              cur_tick_nxt  = '0;
              cur_tempo_nxt = tempo0_r;
              sum_nxt       = '0;
              state_nxt     = tmap_pkg::S_READ;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      tmap_pkg::S_READ: begin
        // Read of entry k is issued here; at the end of the map close out
        if (k_r == count_r) begin
          mul_a_nxt = t_r - cur_tick_r;
          mul_b_nxt = cur_tempo_r;
          final_nxt = 1'b1;
          state_nxt = tmap_pkg::S_MUL;
        end else begin
          state_nxt = tmap_pkg::S_CMP;
        end
      end
      tmap_pkg::S_CMP: begin
        mul_b_nxt = cur_tempo_r;
        state_nxt = tmap_pkg::S_MUL;
        if (ram_rdata.tick < t_r) begin
          mul_a_nxt     = ram_rdata.tick - cur_tick_r;
          cur_tick_nxt  = ram_rdata.tick;
          cur_tempo_nxt = ram_rdata.tempo;
          final_nxt     = 1'b0;
        end else begin
          // Map is ascending: no later entry lies below the tick
          mul_a_nxt = t_r - cur_tick_r;
          final_nxt = 1'b1;
        end
      end
      tmap_pkg::S_MUL: begin
        prod_nxt  = TIME_W'({24'd0, mul_a_r} * {32'd0, mul_b_r});
        state_nxt = tmap_pkg::S_ACC;
      end
      tmap_pkg::S_ACC: begin
        sum_nxt = sum_r + prod_r;
        if (final_r) begin
          rem_nxt     = '0;
          bit_cnt_nxt = DCW'(TIME_W - 1);
          state_nxt   = tmap_pkg::S_DIV;
        end else begin
          k_nxt     = k_r + COUNT_ONE;
          state_nxt = tmap_pkg::S_READ;
        end
      end
      tmap_pkg::S_DIV: begin
        // Restoring division, one quotient bit shifted into the sum per cycle
        rem_nxt = q_bit ? TPQ_W'(rem_sh - {1'b0, divisor}) : rem_sh[TPQ_W-1:0];
        sum_nxt = {sum_r[TIME_W-2:0], q_bit};
        if (bit_cnt_r == '0) begin
          out_time_nxt  = {sum_r[TIME_W-2:0], q_bit};
          out_stat_nxt  = tmap_pkg::STAT_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = tmap_pkg::S_IDLE;
        end else begin
          bit_cnt_nxt = bit_cnt_r - DCW'(1);
        end
      end
      default: begin
        state_nxt = tmap_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmap_pkg::S_IDLE;
      tpq_r       <= tmap_pkg::TPQ_RESET;
      tempo0_r    <= tmap_pkg::DEFAULT_TEMPO;
      dflt_r      <= 1'b1;
      count_r     <= COUNT_ONE;
      last_tick_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        tpq_r <= cfg_wdata;
      end
      tempo0_r    <= tempo0_nxt;
      dflt_r      <= dflt_nxt;
      count_r     <= count_nxt;
      last_tick_r <= last_tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    k_r         <= k_nxt;
    cur_tick_r  <= cur_tick_nxt;
    cur_tempo_r <= cur_tempo_nxt;
    final_r     <= final_nxt;
    mul_a_r     <= mul_a_nxt;
    mul_b_r     <= mul_b_nxt;
    prod_r      <= prod_nxt;
    sum_r       <= sum_nxt;
    rem_r       <= rem_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    out_time_r  <= out_time_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_stat_r, out_time_r};

endmodule

// File: rtl/tmap_chk.sv
// ----------------------------------------------------------------------------
// Tempo map port checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module tmap_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // One request in flight: no new request while a result waits
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while a result is pending");

  // A taken request closes the input; checked just after the take
  a_close_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still open after a request was taken");

  // A rejected append carries no time
  a_reject_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[57:56] != tmap_pkg::STAT_OK) |->
      (out_tdata[55:0] == '0) && (out_tdata[63:58] == '0))
    else $error("rejected append with nonzero time");

  // Clear and append answer in the very next cycle
  a_fast_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    ((in_tuser == tmap_pkg::ACT_CLEAR) || (in_tuser == tmap_pkg::ACT_APPEND)) |=>
      out_tvalid)
    else $error("clear or append result late");

endmodule

bind tempo_map_tick_to_time tmap_chk u_tmap_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
